// ===== rtl/kdaq_pkg.sv =====
package kdaq_pkg;

  // Default sizes
  localparam int NUM_KEYS_DEF   = 4;
  localparam int RING_DEPTH_DEF = 8;

  // Fixed field widths
  localparam int PIN_W      = 4;
  localparam int DEB_W      = 8;
  localparam int TICK_W     = 16;
  localparam int CODE_W     = 3;
  localparam int LEFT_W     = 3;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_PRESSED_LEVEL   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_TICKS  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_START    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_INTERVAL = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_MASK     = 3'd4;

  // Request actions
  localparam logic ACT_SCAN = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic              action;
    logic [PIN_W-1:0]  pin_levels;
  } req_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] event_code;
    logic [LEFT_W-1:0] events_left;
  } rsp_item_t;

  // Settings every key lane sees
  typedef struct packed {
    logic              pressed_level;
    logic [DEB_W-1:0]  debounce_ticks;
    logic [TICK_W-1:0] repeat_start_ticks;
    logic [TICK_W-1:0] repeat_interval_ticks;
  } lane_cfg_t;

endpackage

// ===== rtl/key_debounce_autorepeat_queue_core.sv =====
// Key debouncer with auto-repeat and an event queue. Each request is either a
// scan tick carrying the raw pin levels of the keys or a read of one queued
// event. On a scan tick every key runs its own lane in parallel: a level
// change restarts the debounce count, a level steady for debounce_ticks
// becomes the stable level and a new press queues the key's event, and a held
// repeat-enabled key queues repeats after repeat_start_ticks, then every
// repeat_interval_ticks. Events found in one tick enter the ring in key order
// (key 0 first), all in that same cycle; the ring keeps RING_DEPTH-1 events
// and drops the oldest when full. A scan tick gives no response; a read gives
// one response with the event code (0 when empty) and the count left. One
// request is taken every clock; the response register is the only stage, so a
// read's response appears the cycle after its request. Scan ticks are still
// taken while a response waits; a read waits only while the response register
// is occupied and not being drained. Configuration writes are always
// accepted; indexes beyond the register list are ignored. No clearing pass
// follows reset.
module key_debounce_autorepeat_queue_core
  import kdaq_pkg::*;
#(
  parameter int NUM_KEYS   = NUM_KEYS_DEF,
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_item_t             req_data,
  // response channel
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_item_t             rsp_data,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  lane_cfg_t         lane_cfg;
  logic [PIN_W-1:0]  repeat_enable_mask;

  logic              req_fire, scan_fire, read_fire;
  logic [NUM_KEYS-1:0] push;
  rsp_item_t         rd_item;

  assign cfg_ready = 1'b1;

  // a read needs the response register; a scan tick never does
  assign req_ready = !rsp_valid || rsp_ready || (req_data.action == ACT_SCAN);
  assign req_fire  = req_valid && req_ready;
  assign scan_fire = req_fire && (req_data.action == ACT_SCAN);
  assign read_fire = req_fire && (req_data.action == ACT_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_cfg.pressed_level         <= 1'b0;
      lane_cfg.debounce_ticks        <= DEB_W'(2);
      lane_cfg.repeat_start_ticks    <= TICK_W'(50);
      lane_cfg.repeat_interval_ticks <= TICK_W'(10);
      repeat_enable_mask             <= PIN_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRESSED_LEVEL:   lane_cfg.pressed_level         <= cfg_data[0];
        REG_DEBOUNCE_TICKS:  lane_cfg.debounce_ticks        <= cfg_data[DEB_W-1:0];
        REG_REPEAT_START:    lane_cfg.repeat_start_ticks    <= cfg_data[TICK_W-1:0];
        REG_REPEAT_INTERVAL: lane_cfg.repeat_interval_ticks <= cfg_data[TICK_W-1:0];
        REG_REPEAT_MASK:     repeat_enable_mask             <= cfg_data[PIN_W-1:0];
        default: ;
      endcase
    end
  end

  // one lane per key; keys past the pin field see a low pin, no repeat
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic pin_k, rep_k;
    if (k < PIN_W) begin : g_pin
      assign pin_k = req_data.pin_levels[k];
      assign rep_k = repeat_enable_mask[k];
    end else begin : g_nopin
      assign pin_k = 1'b0;
      assign rep_k = 1'b0;
    end
    kdaq_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .tick   (scan_fire),
      .pin    (pin_k),
      .rep_en (rep_k),
      .cfg    (lane_cfg),
      .push   (push[k])
    );
  end

  // merge the lanes' events into the ring; reads pop from it
  kdaq_merge #(
    .NUM_KEYS   (NUM_KEYS),
    .RING_DEPTH (RING_DEPTH)
  ) u_merge (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .pop     (read_fire),
    .rd_item (rd_item)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (read_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read_fire) begin
      rsp_data <= rd_item;
    end
  end

endmodule

// ===== rtl/kdaq_lane.sv =====
module kdaq_lane
  import kdaq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      tick,
  input  logic      pin,
  input  logic      rep_en,
  input  lane_cfg_t cfg,
  output logic      push
);

  logic              last_level, last_level_next;
  logic              stable_level, stable_level_next;
  logic [DEB_W-1:0]  steady_count, steady_count_next;
  logic [TICK_W-1:0] hold_count, hold_count_next;
  logic [TICK_W-1:0] rpt_count, rpt_count_next;

  logic              raw;
  logic [DEB_W-1:0]  steady_inc;
  logic [TICK_W:0]   rpt_sum;

  assign raw        = (pin == cfg.pressed_level);
  assign steady_inc = steady_count + DEB_W'(1);
  assign rpt_sum    = {1'b0, rpt_count} + (TICK_W+1)'(1);

  always_comb begin
    last_level_next   = last_level;
    stable_level_next = stable_level;
    steady_count_next = steady_count;
    hold_count_next   = hold_count;
    rpt_count_next    = rpt_count;
    push              = 1'b0;
    if (tick) begin
      if (raw != last_level) begin
        // level moved: restart debounce
        last_level_next   = raw;
        steady_count_next = '0;
        hold_count_next   = '0;
        rpt_count_next    = '0;
      end else if (steady_count < cfg.debounce_ticks) begin
        steady_count_next = steady_inc;
        if (steady_inc == cfg.debounce_ticks && raw != stable_level) begin
          stable_level_next = raw;
          push              = raw;
          hold_count_next   = '0;
          rpt_count_next    = '0;
        end
      end else if (stable_level && rep_en) begin
        if (hold_count < cfg.repeat_start_ticks) begin
          hold_count_next = hold_count + TICK_W'(1);
          rpt_count_next  = '0;
        end else if (rpt_sum >= {1'b0, cfg.repeat_interval_ticks}) begin
          rpt_count_next = '0;
          push           = 1'b1;
        end else begin
          rpt_count_next = rpt_sum[TICK_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level   <= 1'b0;
      stable_level <= 1'b0;
      steady_count <= '1;
      hold_count   <= '0;
      rpt_count    <= '0;
    end else begin
      last_level   <= last_level_next;
      stable_level <= stable_level_next;
      steady_count <= steady_count_next;
      hold_count   <= hold_count_next;
      rpt_count    <= rpt_count_next;
    end
  end

endmodule

// ===== rtl/kdaq_merge.sv =====
module kdaq_merge
  import kdaq_pkg::*;
#(
  parameter int NUM_KEYS   = NUM_KEYS_DEF,
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [NUM_KEYS-1:0] push,
  input  logic                pop,
  output rsp_item_t           rd_item
);

  localparam int PW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int TN  = RING_DEPTH + NUM_KEYS;
  localparam int TW  = $clog2(TN);
  localparam int KW  = $clog2(NUM_KEYS + 1);
  localparam int LW  = (PW > LEFT_W) ? PW : LEFT_W;
  localparam logic [TW-1:0] MAX_FILL = TW'(RING_DEPTH - 1);

  logic [CODE_W-1:0] ring [RING_DEPTH];
  logic [PW-1:0]     head, tail, fill;

  logic [PW-1:0]     wrap_tbl [TN];
  logic [KW-1:0]     offs     [NUM_KEYS];
  logic [PW-1:0]     pos      [NUM_KEYS];
  logic [KW-1:0]     n_push;
  logic [TW-1:0]     fill_sum, excess;
  logic [LW-1:0]     left_ext;

  // reduction of a small sum modulo the ring depth
  always_comb begin
    for (int v = 0; v < TN; v++) begin
      wrap_tbl[v] = PW'(v % RING_DEPTH);
    end
  end

  // slot of each key's event: tail plus pushes from lower keys
  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      offs[i] = KW'($countones(push & NUM_KEYS'((1 << i) - 1)));
      pos[i]  = wrap_tbl[TW'(tail) + TW'(offs[i])];
    end
  end

  assign n_push   = KW'($countones(push));
  assign fill_sum = TW'(fill) + TW'(n_push);
  assign excess   = fill_sum - MAX_FILL;

  assign left_ext            = LW'(fill) - LW'(1);
  assign rd_item.event_code  = (fill != '0) ? ring[head] : '0;
  assign rd_item.events_left = (fill != '0) ? left_ext[LEFT_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else if (n_push != '0) begin
      tail <= wrap_tbl[TW'(tail) + TW'(n_push)];
      if (fill_sum > MAX_FILL) begin
        // full: oldest entries drop out
        head <= wrap_tbl[TW'(head) + excess];
        fill <= PW'(RING_DEPTH - 1);
      end else begin
        fill <= fill_sum[PW-1:0];
      end
    end else if (pop && fill != '0) begin
      head <= wrap_tbl[TW'(head) + TW'(1)];
      fill <= fill - PW'(1);
    end
  end

  // later keys win a shared slot, as in sequential pushing
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (push[i]) begin
        ring[pos[i]] <= CODE_W'(i + 1);
      end
    end
  end

endmodule

// ===== bench/tb_key_debounce_autorepeat_queue_core.sv =====
`timescale 1ns / 100ps

module tb_key_debounce_autorepeat_queue_core;
  import kdaq_pkg::*;

  // Event codes as the block reports them: key index + 1, zero for an empty queue
  localparam logic [CODE_W-1:0] EV_NONE  = 3'd0;
  localparam logic [CODE_W-1:0] EV_UP    = 3'd1;
  localparam logic [CODE_W-1:0] EV_DOWN  = 3'd2;
  localparam logic [CODE_W-1:0] EV_ENTER = 3'd3;
  localparam logic [CODE_W-1:0] EV_BACK  = 3'd4;

  // First register index past the register list; writes there are dropped
  localparam logic [REG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd5;

  localparam int N_DIRECTED   = 25;
  localparam int N_PHASES     = 8;
  localparam int DRAIN_CYCLES = 8;        // response register is one stage deep
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // One directed request; the response is typed in only where it is obvious
  typedef struct packed {
    req_item_t req;
    bit        typed;
    rsp_item_t rsp;
  } directed_row_t;

  // One run phase: register settings plus the shape of its random requests
  typedef struct packed {
    logic              pressed;
    logic [DEB_W-1:0]  debounce;
    logic [TICK_W-1:0] rep_start;
    logic [TICK_W-1:0] rep_interval;
    logic [3:0]        rep_mask;
    bit                rand_cfg;   // pick small random settings instead
    int                items;
    int                run_max;    // longest stretch of one pin pattern
    int                read_pct;
    int                noise_pct;  // one-tick glitches inside a stretch
    idle_mode_t        idle;
    int                hold_off;   // long receiver stall at phase start
  } phase_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_item_t             req_data  = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rsp_item_t             rsp_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  key_debounce_autorepeat_queue_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Key/queue predictor: settings, per-key debounce and repeat state, event ring
  // ---------------------------------------------------------------------------
  logic              key_press_pin     = 1'b0;
  logic [DEB_W-1:0]  key_debounce      = 8'd2;
  logic [TICK_W-1:0] key_rep_start     = 16'd50;
  logic [TICK_W-1:0] key_rep_interval  = 16'd10;
  logic [3:0]        key_rep_mask      = 4'h3;

  logic [NUM_KEYS_DEF-1:0] key_last   = '0;
  logic [NUM_KEYS_DEF-1:0] key_stable = '0;
  logic [DEB_W-1:0]  key_steady [NUM_KEYS_DEF] = '{default: 8'hFF};
  logic [TICK_W-1:0] key_hold   [NUM_KEYS_DEF] = '{default: '0};
  logic [TICK_W-1:0] key_repeat [NUM_KEYS_DEF] = '{default: '0};

  logic [CODE_W-1:0] event_ring [RING_DEPTH_DEF] = '{default: '0};
  logic [2:0]        ring_rd = '0;
  logic [2:0]        ring_wr = '0;

  // Responses still owed by the block, oldest first
  rsp_item_t read_results [$];

  int mismatches    = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_len      = 0;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  // Full ring drops its oldest entry; one slot always stays empty
  function automatic void push_event(input logic [CODE_W-1:0] code);
    logic [2:0] next;
    next = ring_wr + 3'd1;
    if (next == ring_rd) ring_rd = ring_rd + 3'd1;
    event_ring[ring_wr] = code;
    ring_wr = next;
  endfunction

  function automatic void predict_request(input req_item_t r, output rsp_item_t rsp);
    logic              raw;
    logic [TICK_W-1:0] rep_next;
    rsp = '0;
    if (r.action == ACT_SCAN) begin
      // keys in index order so same-tick events queue key 0 first
      for (int k = 0; k < NUM_KEYS_DEF; k++) begin
        raw = (r.pin_levels[k] == key_press_pin);
        if (raw != key_last[k]) begin
          key_last[k]   = raw;
          key_steady[k] = '0;
          key_hold[k]   = '0;
          key_repeat[k] = '0;
        end else if (key_steady[k] < key_debounce) begin
          key_steady[k] = key_steady[k] + 8'd1;
          if (key_steady[k] == key_debounce && raw != key_stable[k]) begin
            key_stable[k] = raw;
            if (raw) push_event(CODE_W'(k + 1));
            key_hold[k]   = '0;
            key_repeat[k] = '0;
          end
        end else if (key_stable[k] && key_rep_mask[k]) begin
          if (key_hold[k] < key_rep_start) begin
            key_hold[k]   = key_hold[k] + 16'd1;
            key_repeat[k] = '0;
          end else begin
            // zero interval falls through here too: a repeat every tick
            rep_next = key_repeat[k] + 16'd1;
            if (rep_next >= key_rep_interval) begin
              key_repeat[k] = '0;
              push_event(CODE_W'(k + 1));
            end else begin
              key_repeat[k] = rep_next;
            end
          end
        end
      end
    end else begin
      if (ring_rd != ring_wr) begin
        rsp.event_code = event_ring[ring_rd];
        ring_rd = ring_rd + 3'd1;
      end
      rsp.events_left = ring_wr - ring_rd;
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Request side: random idle gap, then hold valid until accepted
  // ---------------------------------------------------------------------------
  task automatic send_request(input req_item_t r, input bit typed, input rsp_item_t typed_rsp);
    int        gap;
    rsp_item_t want;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (!req_ready);
    predict_request(r, want);
    if (r.action == ACT_READ) read_results.push_back(typed ? typed_rsp : want);
  endtask

  // Register write; bits above the field carry junk the block must drop.
  // The caller lowers cfg_valid after the last write of a batch.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] keep;
    logic [CFG_DATA_W-1:0] junk;
    logic [CFG_DATA_W-1:0] word;
    case (idx)
      REG_PRESSED_LEVEL:  keep = 16'h0001;
      REG_DEBOUNCE_TICKS: keep = 16'h00FF;
      REG_REPEAT_MASK:    keep = 16'h000F;
      default:            keep = 16'hFFFF;
    endcase
    junk = CFG_DATA_W'($urandom);
    word = (junk & ~keep) | (value & keep);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PRESSED_LEVEL:   key_press_pin     = word[0];
      REG_DEBOUNCE_TICKS:  key_debounce      = word[DEB_W-1:0];
      REG_REPEAT_START:    key_rep_start     = word;
      REG_REPEAT_INTERVAL: key_rep_interval  = word;
      REG_REPEAT_MASK:     key_rep_mask      = word[3:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random stalls, plus long hold-offs on request from the
  // main sequence so reads back up and the block stops taking requests
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = hold_len;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every accepted response is matched against the oldest owed one
  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (read_results.size() == 0) begin
        report_mismatch($sformatf("response %0d/%0d with no read pending",
                                  rsp_data.event_code, rsp_data.events_left));
      end else begin
        want = read_results.pop_front();
        if (rsp_data.event_code !== want.event_code)
          report_mismatch($sformatf("event_code got %0d want %0d",
                                    rsp_data.event_code, want.event_code));
        if (rsp_data.events_left !== want.events_left)
          report_mismatch($sformatf("events_left got %0d want %0d",
                                    rsp_data.events_left, want.events_left));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("key_debounce_autorepeat_queue_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed requests under reset settings (pressed = pin low, debounce 2).
  // Pins all high means all keys released.
  // ---------------------------------------------------------------------------
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{'{ACT_READ, 4'h0}, 1'b1, '{EV_NONE, 3'd0}},   // empty queue after reset
    '{'{ACT_SCAN, 4'hF}, 1'b0, '0},                 // released, settled
    '{'{ACT_SCAN, 4'h0}, 1'b0, '0},                 // all keys go down
    '{'{ACT_SCAN, 4'h0}, 1'b0, '0},
    '{'{ACT_SCAN, 4'h0}, 1'b0, '0},                 // debounced: four presses queued
    '{'{ACT_READ, 4'hA}, 1'b1, '{EV_UP, 3'd3}},
    '{'{ACT_READ, 4'h5}, 1'b1, '{EV_DOWN, 3'd2}},
    '{'{ACT_SCAN, 4'hF}, 1'b0, '0},                 // release, no events
    '{'{ACT_SCAN, 4'hF}, 1'b0, '0},
    '{'{ACT_SCAN, 4'hF}, 1'b0, '0},
    '{'{ACT_READ, 4'h0}, 1'b1, '{EV_ENTER, 3'd1}},
    '{'{ACT_READ, 4'hF}, 1'b1, '{EV_BACK, 3'd0}},
    '{'{ACT_READ, 4'h3}, 1'b1, '{EV_NONE, 3'd0}},   // drained
    '{'{ACT_SCAN, 4'h0}, 1'b0, '0},                 // press again
    '{'{ACT_SCAN, 4'h0}, 1'b0, '0},
    '{'{ACT_SCAN, 4'h0}, 1'b0, '0},
    '{'{ACT_SCAN, 4'hF}, 1'b0, '0},
    '{'{ACT_SCAN, 4'hF}, 1'b0, '0},
    '{'{ACT_SCAN, 4'hF}, 1'b0, '0},
    '{'{ACT_SCAN, 4'h0}, 1'b0, '0},
    '{'{ACT_SCAN, 4'h0}, 1'b0, '0},
    '{'{ACT_SCAN, 4'h0}, 1'b0, '0},                 // eighth event overflows the ring
    '{'{ACT_READ, 4'hC}, 1'b1, '{EV_DOWN, 3'd6}},   // oldest "up" was dropped
    '{'{ACT_SCAN, 4'h5}, 1'b0, '0},                 // bounce on up and enter
    '{'{ACT_READ, 4'h0}, 1'b1, '{EV_ENTER, 3'd5}}
  };

  // Phases: near-default, low extremes, zero debounce and interval, mixed, high extremes
  // (long steady stretches, no noise), zero start with the longest interval, then random settings
  phase_t phase_plan [N_PHASES] = '{
    '{1'b0, 8'd2,   16'd6,     16'd3,     4'h3, 1'b0, 120, 20,  25, 6, IDLE_NONE,     80},
    '{1'b0, 8'd1,   16'd0,     16'd1,     4'hF, 1'b0, 120, 10,  30, 6, IDLE_SENDER,   0},
    '{1'b1, 8'd0,   16'd2,     16'd0,     4'h5, 1'b0, 120, 10,  30, 6, IDLE_RECEIVER, 0},
    '{1'b1, 8'd3,   16'd4,     16'd2,     4'hA, 1'b0, 120, 20,  25, 6, IDLE_BOTH,     0},
    '{1'b1, 8'd255, 16'd65535, 16'd65535, 4'h0, 1'b0, 300, 300, 5,  0, IDLE_NONE,     0},
    '{1'b0, 8'd2,   16'd0,     16'd65535, 4'hF, 1'b0, 110, 15,  30, 6, IDLE_SENDER,   60},
    '{1'b0, 8'd0,   16'd0,     16'd0,     4'h0, 1'b1, 120, 20,  25, 6, IDLE_RECEIVER, 0},
    '{1'b0, 8'd0,   16'd0,     16'd0,     4'h0, 1'b1, 120, 20,  25, 6, IDLE_BOTH,     0}
  };

  initial begin
    phase_t     ph;
    req_item_t  req;
    logic [3:0] run_pins;
    logic [3:0] flip;
    int         run_left;
    run_pins = '0;
    run_left = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r])
      send_request(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].rsp);
    req_valid <= 1'b0;

    foreach (phase_plan[p]) begin
      ph = phase_plan[p];
      // settings change only once the block is quiet
      while (read_results.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);

      if (ph.rand_cfg) begin
        ph.pressed      = 1'($urandom_range(1, 0));
        ph.debounce     = DEB_W'($urandom_range(5, 1));
        ph.rep_start    = TICK_W'($urandom_range(10, 0));
        ph.rep_interval = TICK_W'($urandom_range(4, 0));
        ph.rep_mask     = 4'($urandom);
      end
      write_reg(REG_PRESSED_LEVEL, {15'd0, ph.pressed});
      write_reg(REG_DEBOUNCE_TICKS, {8'd0, ph.debounce});
      write_reg(REG_REPEAT_START, ph.rep_start);
      write_reg(REG_REPEAT_INTERVAL, ph.rep_interval);
      write_reg(REG_REPEAT_MASK, {12'd0, ph.rep_mask});
      // must be ignored
      write_reg(REG_IDX_W'($urandom_range(7, REG_FIRST_UNUSED)), CFG_DATA_W'($urandom));
      cfg_valid <= 1'b0;

      send_idle_pct = (ph.idle == IDLE_SENDER) ? 58 : (ph.idle == IDLE_BOTH) ? 11 : 0;
      stall_pct     = (ph.idle == IDLE_RECEIVER) ? 58 : (ph.idle == IDLE_BOTH) ? 11 : 0;
      if (ph.hold_off != 0) begin
        hold_len = ph.hold_off;
        hold_requests++;
      end

      // Mostly steady pin stretches so presses debounce and held keys repeat;
      // occasional one-tick glitches restart the debounce count.
      for (int n = 0; n < ph.items; n++) begin
        if ($urandom_range(99) < ph.read_pct) begin
          req.action     = ACT_READ;
          req.pin_levels = PIN_W'($urandom);
        end else begin
          if (run_left == 0) begin
            run_pins = 4'($urandom);
            run_left = $urandom_range(1, 0) ? ph.run_max : $urandom_range(ph.run_max, 1);
          end
          run_left--;
          req.action     = ACT_SCAN;
          req.pin_levels = run_pins;
          if ($urandom_range(99) < ph.noise_pct) begin
            flip = 4'($urandom_range(15, 1));
            req.pin_levels = run_pins ^ flip;
          end
        end
        send_request(req, 1'b0, '0);
      end
      req_valid <= 1'b0;
    end

    while (read_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("key_debounce_autorepeat_queue_core test passed");
    end else begin
      $display("key_debounce_autorepeat_queue_core test failed");
    end
    $finish;
  end

endmodule
